// ===== design/rsd_pkg.sv =====
// rsd_pkg: shared types and constants for the record stream deframer.
// No dependencies; compiled first.
package rsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned TS_W     = 32;
    localparam int unsigned POS_W    = 3;

    // Header byte positions, in arrival order
    localparam logic [POS_W-1:0] POS_ID    = 3'd0;
    localparam logic [POS_W-1:0] POS_TYPE  = 3'd1;
    localparam logic [POS_W-1:0] POS_LEN0  = 3'd2;
    localparam logic [POS_W-1:0] POS_LEN1  = 3'd3;
    localparam logic [POS_W-1:0] POS_TS0   = 3'd4;
    localparam logic [POS_W-1:0] POS_TS1   = 3'd5;
    localparam logic [POS_W-1:0] POS_TS2   = 3'd6;
    localparam logic [POS_W-1:0] POS_TS3   = 3'd7;

    // One result transaction
    typedef struct packed {
        logic              header_valid;
        logic [BYTE_W-1:0] record_id;
        logic [BYTE_W-1:0] record_type;
        logic [LEN_W-1:0]  payload_length;
        logic [TS_W-1:0]   timestamp;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              record_last;
        logic              truncated;
    } result_t;

endpackage

// ===== design/rsd_channels.sv =====
// Valid/ready channel interfaces for the record stream deframer.
// Depends on rsd_pkg for field widths.
interface rsd_byte_if;
    import rsd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface rsd_rec_if;
    import rsd_pkg::*;
    logic              valid;
    logic              ready;
    logic              header_valid;
    logic [BYTE_W-1:0] record_id;
    logic [BYTE_W-1:0] record_type;
    logic [LEN_W-1:0]  payload_length;
    logic [TS_W-1:0]   timestamp;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              record_last;
    logic              truncated;

    modport source (output valid, output header_valid, output record_id, output record_type,
                    output payload_length, output timestamp, output payload_valid,
                    output payload_byte, output record_last, output truncated,
                    input ready);
    modport sink   (input valid, input header_valid, input record_id, input record_type,
                    input payload_length, input timestamp, input payload_valid,
                    input payload_byte, input record_last, input truncated,
                    output ready);
endinterface

// ===== design/rsd_parser.sv =====
// rsd_parser: header/payload tracking state and per-byte result forming.
// Depends on rsd_pkg and rsd_byte_if.
module rsd_parser (
    input  logic            clk,
    input  logic            rst_n,
    rsd_byte_if.sink        byte_in,
    input  logic            stage_ready,
    output logic            push,
    output rsd_pkg::result_t result
);
    import rsd_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              in_payload_reg, in_payload_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;

    logic              accept;
    logic              has_result;
    logic [LEN_W-1:0]  rem_dec;
    logic              pay_last;
    logic [BYTE_W-1:0] b;
    logic              b_end;

    assign byte_in.ready = stage_ready;
    assign accept        = byte_in.valid && stage_ready;
    assign push          = accept && has_result;
    assign b             = byte_in.data_byte;
    assign b_end         = byte_in.buffer_end;
    assign rem_dec       = rem_reg - LEN_W'(1);
    assign pay_last      = (rem_dec == '0);

    always_comb
    begin
        pos_next        = pos_reg;
        in_payload_next = in_payload_reg;
        id_next         = id_reg;
        type_next       = type_reg;
        len_next        = len_reg;
        ts_next         = ts_reg;
        rem_next        = rem_reg;
        has_result      = 1'b0;
        result          = '0;

        if (in_payload_reg)
        begin
            has_result            = 1'b1;
            result.record_id      = id_reg;
            result.record_type    = type_reg;
            result.payload_length = len_reg;
            result.timestamp      = ts_reg;
            result.payload_valid  = 1'b1;
            result.payload_byte   = b;
            result.record_last    = pay_last;
            result.truncated      = b_end && !pay_last;
            if (pay_last || b_end)
            begin
                in_payload_next = 1'b0;
                pos_next        = POS_ID;
                rem_next        = '0;
            end
            else
            begin
                rem_next = rem_dec;
            end
        end
        else
        begin
            unique case (pos_reg)
                POS_ID:   id_next         = b;
                POS_TYPE: type_next       = b;
                POS_LEN0: len_next[7:0]   = b;
                POS_LEN1: len_next[15:8]  = b;
                POS_TS0:  ts_next[7:0]    = b;
                POS_TS1:  ts_next[15:8]   = b;
                POS_TS2:  ts_next[23:16]  = b;
                POS_TS3:  ts_next[31:24]  = b;
                default:  ts_next         = ts_reg;
            endcase

            if (pos_reg != POS_TS3)
            begin
                if (b_end)
                begin
                    // buffer ran out inside the header: bare truncation flag
                    has_result       = 1'b1;
                    result.truncated = 1'b1;
                    pos_next         = POS_ID;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            else
            begin
                pos_next              = POS_ID;
                has_result            = 1'b1;
                result.header_valid   = 1'b1;
                result.record_id      = id_reg;
                result.record_type    = type_reg;
                result.payload_length = len_reg;
                result.timestamp      = ts_next;
                if (len_reg == '0)
                begin
                    result.record_last = 1'b1;
                end
                else
                begin
                    result.truncated = b_end;
                    if (!b_end)
                    begin
                        in_payload_next = 1'b1;
                        rem_next        = len_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_ID;
            in_payload_reg <= 1'b0;
            id_reg         <= '0;
            type_reg       <= '0;
            len_reg        <= '0;
            ts_reg         <= '0;
            rem_reg        <= '0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            in_payload_reg <= in_payload_next;
            id_reg         <= id_next;
            type_reg       <= type_next;
            len_reg        <= len_next;
            ts_reg         <= ts_next;
            rem_reg        <= rem_next;
        end
    end

    // payload phase always has bytes left and sits at header position zero
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (rem_reg != '0 && pos_reg == POS_ID))
        else $error("payload phase with no bytes left or header position set");

    // the final payload byte closes the record
    a_last_exits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_payload_reg && rem_reg == LEN_W'(1)) |=> !in_payload_reg)
        else $error("payload phase not left after last byte");

    // a completed record is never also flagged as truncated
    a_last_not_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(result.record_last && result.truncated))
        else $error("record_last and truncated together");

    // header and payload results are exclusive
    a_hdr_pay_excl: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(result.header_valid && result.payload_valid))
        else $error("header and payload flagged in one result");

endmodule

// ===== design/rsd_out_stage.sv =====
// rsd_out_stage: output register with skid entry, decoupling the two sides.
// Depends on rsd_pkg and rsd_rec_if.
module rsd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rsd_pkg::result_t push_data,
    output logic             stage_ready,
    rsd_rec_if.source        rec_out
);
    import rsd_pkg::*;

    logic    main_v_reg, main_v_next;
    logic    skid_v_reg, skid_v_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign stage_ready = !skid_v_reg;
    assign pop         = main_v_reg && rec_out.ready;

    always_comb
    begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (pop || !main_v_reg)
        begin
            // skid full implies no push this cycle
            main_v_next = skid_v_reg || push;
            main_next   = skid_v_reg ? skid_reg : push_data;
            skid_v_next = 1'b0;
        end
        else if (push)
        begin
            skid_v_next = 1'b1;
            skid_next   = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign rec_out.valid          = main_v_reg;
    assign rec_out.header_valid   = main_reg.header_valid;
    assign rec_out.record_id      = main_reg.record_id;
    assign rec_out.record_type    = main_reg.record_type;
    assign rec_out.payload_length = main_reg.payload_length;
    assign rec_out.timestamp      = main_reg.timestamp;
    assign rec_out.payload_valid  = main_reg.payload_valid;
    assign rec_out.payload_byte   = main_reg.payload_byte;
    assign rec_out.record_last    = main_reg.record_last;
    assign rec_out.truncated      = main_reg.truncated;

endmodule

// ===== design/record_stream_deframer.sv =====
// record_stream_deframer: top level, parser followed by output register stage.
// Depends on rsd_pkg, rsd_channels, rsd_parser and rsd_out_stage.
//
//  channel   dir  modport  payload
//  byte_in   in   sink     data_byte[7:0], buffer_end
//  rec_out   out  source   header fields, payload byte, record_last, truncated
//
// One byte transaction is taken per clock while byte_in.ready is high; each byte
// gives zero or one result, which is registered in the output stage.
// rst_n is asynchronous and active low; it returns the parser to the id byte.
// A stalled rec_out is absorbed by one skid entry; byte_in.ready drops only
// when both the output register and the skid entry hold results.
// Header bytes before the eighth give no result unless the buffer ends there.
module record_stream_deframer (
    input  logic      clk,
    input  logic      rst_n,
    rsd_byte_if.sink  byte_in,
    rsd_rec_if.source rec_out
);
    import rsd_pkg::*;

    logic    push;
    logic    stage_ready;
    result_t result;

    // byte-wise header collection and payload counting
    rsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_in     (byte_in),
        .stage_ready (stage_ready),
        .push        (push),
        .result      (result)
    );

    // result register with skid entry towards the consumer
    rsd_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_data   (result),
        .stage_ready (stage_ready),
        .rec_out     (rec_out)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for record_stream_deframer, directed table then random records.
// Depends on rsd_pkg, rsd_channels and the deframer RTL; nothing else is read.
module tb_top;
    import rsd_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int ITEM_TARGET      = 1450;    // byte transactions in the whole run
    localparam int QUIET_TAIL       = 200;     // final transactions with no idling on either side
    localparam int LONG_HOLD_AFTER  = 400;     // results checked before the long output stall
    localparam int LONG_HOLD_CYCLES = 40;
    localparam int DRAIN_CYCLES     = 8;       // output register plus skid entry, with margin
    localparam int RUN_LIMIT_CYCLES = 200_000;
    localparam int DIRECTED_ROWS    = 26;

    // One row of the directed table. Where typed is set, want is the result the
    // row must give; otherwise the predictor decides.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              buffer_end;
        logic              typed;
        result_t           want;
    } stim_row_t;

    localparam result_t NO_WANT = '0;
    // Buffer ends inside the header: only the truncation flag is set
    localparam result_t WANT_CUT_HEADER =
        {1'b0, 8'h00, 8'h00, 16'h0000, 32'h0000_0000, 1'b0, 8'h00, 1'b0, 1'b1};
    // Zero-length record ending exactly on the buffer end: header result closes it
    localparam result_t WANT_EMPTY_RECORD =
        {1'b1, 8'hFF, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b1, 1'b0};
    // Buffer ends on the last header byte of a maximum-length record
    localparam result_t WANT_CUT_AFTER_HEADER =
        {1'b1, 8'h00, 8'hFF, 16'hFFFF, 32'h0000_0000, 1'b0, 8'h00, 1'b0, 1'b1};

    logic clk;
    logic rst_n;

    rsd_byte_if byte_in ();
    rsd_rec_if  rec_out ();

    record_stream_deframer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .rec_out (rec_out)
    );

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the parser, advanced once per accepted
    // byte transaction.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  shadow_pos;
    logic              shadow_in_payload;
    logic [BYTE_W-1:0] shadow_id;
    logic [BYTE_W-1:0] shadow_type;
    logic [LEN_W-1:0]  shadow_len;
    logic [TS_W-1:0]   shadow_ts;
    logic [LEN_W-1:0]  shadow_left;

    result_t   records_due [$];    // results predicted but not yet seen on rec_out
    stim_row_t directed_rows [DIRECTED_ROWS];

    int  bytes_sent      = 0;
    int  records_checked = 0;
    int  mismatch_count  = 0;
    bit  idling_on       = 1'b1;   // cleared for the quiet tail of the run
    bit  record_quiet    = 1'b0;   // no input gaps within the current record

    // Advances the shadow parser by one byte; returns 1 when the byte gives a result.
    function automatic bit step_deframer(input logic [BYTE_W-1:0] value,
                                         input logic ends_buffer,
                                         output result_t outcome);
        outcome = '0;

        if (shadow_in_payload)
        begin
            shadow_left                 = shadow_left - LEN_W'(1);
            outcome.record_id           = shadow_id;
            outcome.record_type         = shadow_type;
            outcome.payload_length      = shadow_len;
            outcome.timestamp           = shadow_ts;
            outcome.payload_valid       = 1'b1;
            outcome.payload_byte        = value;
            outcome.record_last         = (shadow_left == '0);
            outcome.truncated           = ends_buffer && (shadow_left != '0);
            if (shadow_left == '0 || ends_buffer)
            begin
                shadow_in_payload = 1'b0;
                shadow_pos        = POS_ID;
                shadow_left       = '0;
            end
            return 1'b1;
        end

        // Header bytes land in their held field; length and timestamp are little-endian
        case (shadow_pos)
            POS_ID:   shadow_id          = value;
            POS_TYPE: shadow_type        = value;
            POS_LEN0: shadow_len[7:0]    = value;
            POS_LEN1: shadow_len[15:8]   = value;
            POS_TS0:  shadow_ts[7:0]     = value;
            POS_TS1:  shadow_ts[15:8]    = value;
            POS_TS2:  shadow_ts[23:16]   = value;
            default:  shadow_ts[31:24]   = value;
        endcase

        if (shadow_pos != POS_TS3)
        begin
            if (ends_buffer)
            begin
                // cut header: flag only, every field zero
                outcome.truncated = 1'b1;
                shadow_pos        = POS_ID;
                return 1'b1;
            end
            shadow_pos = shadow_pos + POS_W'(1);
            return 1'b0;
        end

        shadow_pos             = POS_ID;
        outcome.header_valid   = 1'b1;
        outcome.record_id      = shadow_id;
        outcome.record_type    = shadow_type;
        outcome.payload_length = shadow_len;
        outcome.timestamp      = shadow_ts;
        if (shadow_len == '0)
        begin
            outcome.record_last = 1'b1;    // empty record closes on its header
            return 1'b1;
        end
        outcome.truncated = ends_buffer;
        if (!ends_buffer)
        begin
            shadow_in_payload = 1'b1;
            shadow_left       = shadow_len;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. One call offers one byte and returns once the
    // transaction has been taken; valid stays high into the next call
    // unless a gap is inserted.
    // ------------------------------------------------------------------
    task automatic offer_byte(input logic [BYTE_W-1:0] value, input logic ends_buffer,
                              input logic typed, input result_t want);
        result_t predicted;
        bit      produces;
        int      gap;

        if (idling_on && !record_quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            byte_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_in.valid      <= 1'b1;
        byte_in.data_byte  <= value;
        byte_in.buffer_end <= ends_buffer;
        do
            @(posedge clk);
        while (byte_in.ready !== 1'b1);

        produces = step_deframer(value, ends_buffer, predicted);
        if (typed)
            records_due.push_back(want);
        else if (produces)
            records_due.push_back(predicted);

        bytes_sent++;
        if (bytes_sent >= ITEM_TARGET - QUIET_TAIL)
            idling_on = 1'b0;
    endtask

    // Well-formed record with random content. Lengths are mostly short; now and
    // then the buffer is cut partway through, or ends exactly on the record.
    task automatic send_record();
        logic [BYTE_W-1:0] hdr [8];
        logic [LEN_W-1:0]  len;
        logic [TS_W-1:0]   stamp;
        logic [BYTE_W-1:0] value;
        int                pick;
        int                total;
        int                cut_at;

        pick = $urandom_range(0, 19);
        if (pick < 3)
            len = '0;
        else if (pick < 16)
            len = LEN_W'($urandom_range(1, 8));
        else
            len = LEN_W'($urandom_range(9, 48));
        stamp  = $urandom();
        hdr[0] = BYTE_W'($urandom_range(0, 255));
        hdr[1] = BYTE_W'($urandom_range(0, 255));
        hdr[2] = len[7:0];
        hdr[3] = len[15:8];
        hdr[4] = stamp[7:0];
        hdr[5] = stamp[15:8];
        hdr[6] = stamp[23:16];
        hdr[7] = stamp[31:24];
        total  = 8 + int'(len);

        pick   = $urandom_range(0, 9);
        cut_at = -1;
        if (pick == 0)
            cut_at = $urandom_range(0, total - 2);
        else if (pick == 1)
            cut_at = total - 1;

        record_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < total; i++)
        begin
            value = (i < 8) ? hdr[i] : BYTE_W'($urandom_range(0, 255));
            offer_byte(value, i == cut_at, 1'b0, NO_WANT);
            if (i == cut_at)
                break;
        end
    endtask

    // Short burst of arbitrary bytes. The last one always ends the buffer, so a
    // stray length cannot leave the parser in a long payload.
    task automatic send_noise();
        int n;

        record_quiet = 1'b0;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
            offer_byte(BYTE_W'($urandom_range(0, 255)),
                       (i == n - 1) || ($urandom_range(0, 7) == 0), 1'b0, NO_WANT);
    endtask

    task automatic report_fields(input string tag, input result_t r);
        $display("  %s hv=%0b id=%02h type=%02h len=%04h ts=%08h pv=%0b pb=%02h last=%0b trunc=%0b",
                 tag, r.header_valid, r.record_id, r.record_type, r.payload_length,
                 r.timestamp, r.payload_valid, r.payload_byte, r.record_last, r.truncated);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random records, then drain and verdict.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int pick;

        rst_n              <= 1'b0;
        byte_in.valid      <= 1'b0;
        byte_in.data_byte  <= '0;
        byte_in.buffer_end <= 1'b0;

        shadow_pos        = POS_ID;
        shadow_in_payload = 1'b0;
        shadow_id         = '0;
        shadow_type       = '0;
        shadow_len        = '0;
        shadow_ts         = '0;
        shadow_left       = '0;

        directed_rows = '{
            // buffer ends on the very first byte after reset
            {8'hAB, 1'b1, 1'b1, WANT_CUT_HEADER},
            // empty record, id and timestamp all ones, buffer ends on its last byte
            {8'hFF, 1'b0, 1'b0, NO_WANT},
            {8'h00, 1'b0, 1'b0, NO_WANT},
            {8'h00, 1'b0, 1'b0, NO_WANT},
            {8'h00, 1'b0, 1'b0, NO_WANT},
            {8'hFF, 1'b0, 1'b0, NO_WANT},
            {8'hFF, 1'b0, 1'b0, NO_WANT},
            {8'hFF, 1'b0, 1'b0, NO_WANT},
            {8'hFF, 1'b1, 1'b1, WANT_EMPTY_RECORD},
            // maximum length, buffer ends on the last header byte
            {8'h00, 1'b0, 1'b0, NO_WANT},
            {8'hFF, 1'b0, 1'b0, NO_WANT},
            {8'hFF, 1'b0, 1'b0, NO_WANT},
            {8'hFF, 1'b0, 1'b0, NO_WANT},
            {8'h00, 1'b0, 1'b0, NO_WANT},
            {8'h00, 1'b0, 1'b0, NO_WANT},
            {8'h00, 1'b0, 1'b0, NO_WANT},
            {8'h00, 1'b1, 1'b1, WANT_CUT_AFTER_HEADER},
            // two-byte payload, byte order check, buffer ends on the first payload byte
            {8'h5A, 1'b0, 1'b0, NO_WANT},
            {8'h3C, 1'b0, 1'b0, NO_WANT},
            {8'h02, 1'b0, 1'b0, NO_WANT},
            {8'h00, 1'b0, 1'b0, NO_WANT},
            {8'h78, 1'b0, 1'b0, NO_WANT},
            {8'h56, 1'b0, 1'b0, NO_WANT},
            {8'h34, 1'b0, 1'b0, NO_WANT},
            {8'h12, 1'b0, 1'b0, NO_WANT},
            {8'h80, 1'b1, 1'b0, NO_WANT}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_byte(directed_rows[i].data_byte, directed_rows[i].buffer_end,
                       directed_rows[i].typed, directed_rows[i].want);

        // mostly well-formed records, one time in ten a noise burst
        while (bytes_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_noise();
            else
                send_record();
        end
        byte_in.valid <= 1'b0;

        while (records_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (mismatch_count == 0 && records_due.size() == 0)
            $display("[record_stream_deframer] OK");
        else
            $display("[record_stream_deframer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: checks every result transaction against the oldest
    // prediction and drives ready, with short random stalls and one long
    // hold-off that backs the block up into its input.
    // ------------------------------------------------------------------
    initial
    begin : result_checker
        result_t got;
        result_t want;
        int      stall_left;
        bit      long_hold_done;

        stall_left     = 0;
        long_hold_done = 1'b0;
        rec_out.ready <= 1'b0;

        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rec_out.valid === 1'b1 && rec_out.ready === 1'b1)
            begin
                got = {rec_out.header_valid, rec_out.record_id, rec_out.record_type,
                       rec_out.payload_length, rec_out.timestamp, rec_out.payload_valid,
                       rec_out.payload_byte, rec_out.record_last, rec_out.truncated};
                if (records_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result %0d arrived with nothing outstanding", records_checked);
                        report_fields("actual  ", got);
                    end
                end
                else
                begin
                    want = records_due.pop_front();
                    if (got.header_valid   !== want.header_valid   ||
                        got.record_id      !== want.record_id      ||
                        got.record_type    !== want.record_type    ||
                        got.payload_length !== want.payload_length ||
                        got.timestamp      !== want.timestamp      ||
                        got.payload_valid  !== want.payload_valid  ||
                        got.payload_byte   !== want.payload_byte   ||
                        got.record_last    !== want.record_last    ||
                        got.truncated      !== want.truncated)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch on result %0d", records_checked);
                            report_fields("expected", want);
                            report_fields("actual  ", got);
                        end
                    end
                end
                records_checked++;
            end

            // ready for the next cycle
            if (stall_left > 0)
                stall_left--;
            else if (!long_hold_done && records_checked >= LONG_HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD_CYCLES;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 3);
            rec_out.ready <= (stall_left == 0);
        end
    end

    // Hard stop should the block hang
    initial
    begin : run_limit
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("[record_stream_deframer] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rsd_pkg.sv
design/rsd_channels.sv
design/rsd_parser.sv
design/rsd_out_stage.sv
design/record_stream_deframer.sv
tb/sv/tb_top.sv
